// File: rtl/ip_mac_binding_table_core_defines.svh
// Assertion macros shared by the binding table RTL.
// Used by files that include this header; needs clk and rst_n in scope.
`ifndef IP_MAC_BINDING_TABLE_CORE_DEFINES_SVH
`define IP_MAC_BINDING_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IPMAC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("binding table assertion failed");
`define IPMAC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("binding table assertion failed");
`else
`define IPMAC_ASSERT(lbl, cond)
`define IPMAC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: rtl/ipmac_pkg.sv
// Types, status codes and helper functions of the IPv4-to-MAC binding table.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ipmac_pkg;

  localparam int MAC_BYTES = 6;
  localparam int MAC_W     = MAC_BYTES * 8;
  localparam int IP_W      = 32;
  localparam int ENTRY_W   = IP_W + MAC_W;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  typedef struct packed {
    logic             func;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } in_req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [MAC_W-1:0] mac_out;
  } out_rsp_t;

  function automatic logic [IP_W-1:0] swap_bytes32(input logic [IP_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/ipmac_mem.sv
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on ipmac_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none
module ipmac_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [ADDR_W-1:0]            wr_addr,
  input  wire logic [ipmac_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [ADDR_W-1:0]            rd_addr,
  output logic      [ipmac_pkg::ENTRY_W-1:0] rd_data
);

  logic [ipmac_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ip_mac_binding_table_core.sv
// Top level of the IPv4-to-MAC binding table: sequencer, fill counter, result register.
// Depends on ipmac_pkg, ipmac_mem and ip_mac_binding_table_core_defines.svh.
//
// Usage: each request on the in_ channel (in_valid, in_stall, in_req) is an add or a
// lookup and yields exactly one result on the out_ channel (out_valid, out_stall,
// out_rsp). A request is taken when valid is high and stall is low at a clock edge.
// The block works on one request at a time: it walks the filled entries through a
// memory with registered read data, issuing one read per cycle, and stops at the first
// match. The next request is taken only once the result of the last one has been
// registered. Results sit in an output register, so a stalled receiver holds the
// result steady and only delays the block when the next result is ready to leave.
// After a synchronous reset (rst_n low) the table is empty and the block is ready on
// the next cycle; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
`include "ip_mac_binding_table_core_defines.svh"
module ip_mac_binding_table_core #(
  parameter int TABLE_ENTRIES = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ipmac_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ipmac_pkg::out_rsp_t      out_rsp
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                          state_r, state_nxt;
  ipmac_pkg::in_req_t              req_r, req_nxt;
  logic [FILL_W-1:0]               idx_r, idx_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic                            pend_r, pend_nxt;
  logic                            hit_r, hit_nxt;
  logic [IDX_W-1:0]                hit_idx_r, hit_idx_nxt;
  logic [ipmac_pkg::MAC_W-1:0]     hit_mac_r, hit_mac_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ipmac_pkg::out_rsp_t             out_r, out_nxt;

  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic [ipmac_pkg::ENTRY_W-1:0]   rd_data;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic [ipmac_pkg::ENTRY_W-1:0]   wr_data;
  logic [ipmac_pkg::IP_W-1:0]      rd_ip;
  logic [ipmac_pkg::MAC_W-1:0]     rd_mac;
  logic [FILL_W-1:0]               prev_idx;
  logic                            match;

  ipmac_mem #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_ip    = rd_data[ipmac_pkg::ENTRY_W-1 -: ipmac_pkg::IP_W];
  assign rd_mac   = rd_data[ipmac_pkg::MAC_W-1:0];
  assign prev_idx = idx_r - FILL_W'(1);
  assign match    = pend_r && ((req_r.func == ipmac_pkg::FUNC_LOOKUP) ?
                               (rd_ip == req_r.ip_addr) : (rd_mac == req_r.mac_addr));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_mac_nxt   = hit_mac_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = fill_r[IDX_W-1:0];
    wr_data       = {req_r.ip_addr, req_r.mac_addr};

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req;
          if (in_req.func == ipmac_pkg::FUNC_ADD) begin
            req_nxt.ip_addr = ipmac_pkg::swap_bytes32(in_req.ip_addr);
          end
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = prev_idx[IDX_W-1:0];
          hit_mac_nxt = rd_mac;
          pend_nxt    = 1'b0;
          state_nxt   = S_FINISH;
        end else if (idx_r == fill_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + FILL_W'(1);
          pend_nxt = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
          out_nxt.mac_out = '0;
          if (req_r.func == ipmac_pkg::FUNC_LOOKUP) begin
            out_nxt.status = hit_r ? ipmac_pkg::ST_HIT : ipmac_pkg::ST_MISS;
            if (hit_r) begin
              out_nxt.mac_out = hit_mac_r;
            end
          end else if (hit_r) begin
            out_nxt.status = ipmac_pkg::ST_UPDATED;
            wr_en          = 1'b1;
            wr_addr        = hit_idx_r;
          end else if (fill_r != FULL_COUNT) begin
            out_nxt.status = ipmac_pkg::ST_INSERTED;
            wr_en          = 1'b1;
            fill_nxt       = fill_r + FILL_W'(1);
          end else begin
            out_nxt.status = ipmac_pkg::ST_FULL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    idx_r     <= idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_mac_r <= hit_mac_nxt;
    out_r     <= out_nxt;
  end

  `IPMAC_ASSERT(a_fill_bounded, fill_r <= FULL_COUNT)
  `IPMAC_ASSERT_IMPL(a_scan_within_fill, state_r == S_SCAN, idx_r <= fill_r)
  `IPMAC_ASSERT_IMPL(a_hit_below_fill, state_r == S_FINISH && hit_r, FILL_W'(hit_idx_r) < fill_r)
  `IPMAC_ASSERT_IMPL(a_fill_moves_on_insert, $past(rst_n) && fill_r != $past(fill_r),
                     out_valid_r && out_r.status == ipmac_pkg::ST_INSERTED)

endmodule
`default_nettype wire

// File: test/tb_ip_mac_binding_table_core.sv
// Self-checking testbench for ip_mac_binding_table_core: directed adds and lookups,
// then random requests checked in order against a behavioral copy of the table.
// Depends on ipmac_pkg and the RTL of the binding table only.
`timescale 1ns / 1ps
module tb_ip_mac_binding_table_core;

  localparam int TABLE_ENTRIES = 128;
  localparam int N_RANDOM      = 450;
  localparam int IDLE_PCT      = 34;
  localparam int CALM_FIRST    = 200;
  localparam int CALM_LAST     = 260;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int N_PROBES      = 21;

  typedef struct packed {
    logic                        func;
    logic [ipmac_pkg::IP_W-1:0]  ip;
    logic [ipmac_pkg::MAC_W-1:0] mac;
    logic                        typed;
    logic [2:0]                  status;
    logic [ipmac_pkg::MAC_W-1:0] mac_out;
  } probe_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ipmac_pkg::in_req_t  in_req;
  logic                out_valid;
  logic                out_stall;
  ipmac_pkg::out_rsp_t out_rsp;

  logic [ipmac_pkg::IP_W-1:0]  bound_ip  [TABLE_ENTRIES];
  logic [ipmac_pkg::MAC_W-1:0] bound_mac [TABLE_ENTRIES];
  int                          bound_count;

  ipmac_pkg::out_rsp_t         awaited_rsp [$];
  ipmac_pkg::out_rsp_t         head_rsp;
  logic [ipmac_pkg::MAC_W-1:0] added_macs [$];
  logic [ipmac_pkg::IP_W-1:0]  added_ips  [$];
  int                          n_issued;
  int                          n_mismatch;
  int                          idle_cycles;
  bit                          calm;

  // Rows marked typed carry their expected result; the others use the predictor.
  probe_t probes [N_PROBES] = '{
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0, 1'b1, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'hffff_ffff, 48'hffff_ffff_ffff,
      1'b1, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'h0102_0304, 48'h0, 1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'hffff_ffff, 48'hffff_ffff_ffff,
      1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0403_0201, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'hffff_ffff, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0102_0304, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'h0102_0304, 48'h0, 1'b1, ipmac_pkg::ST_UPDATED, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'h0a00_0001, 48'h0, 1'b1, ipmac_pkg::ST_UPDATED, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0100_000a, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0403_0201, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'hffff_ffff, 48'h1234_5678_9abc,
      1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'hffff_ffff, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'h5555_5555, 48'haaaa_aaaa_aaaa,
      1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'haaaa_aaaa, 48'h5555_5555_5555,
      1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h5555_5555, 48'h5555_5555_5555,
      1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'haaaa_aaaa, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'h0000_0000, 48'h0000_0000_0001,
      1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0000_0000, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0},
    '{ipmac_pkg::FUNC_ADD,    32'h8000_0000, 48'h8000_0000_0000,
      1'b1, ipmac_pkg::ST_INSERTED, 48'h0},
    '{ipmac_pkg::FUNC_LOOKUP, 32'h0000_0080, 48'h0, 1'b0, ipmac_pkg::ST_MISS, 48'h0}
  };

  ip_mac_binding_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  always #5 clk = ~clk;

  function automatic logic [ipmac_pkg::IP_W-1:0] to_host(
    input logic [ipmac_pkg::IP_W-1:0] net);
    logic [ipmac_pkg::IP_W-1:0] host;
    int b;
    for (b = 0; b < 4; b++) host[8*b +: 8] = net[8*(3-b) +: 8];
    return host;
  endfunction

  function automatic ipmac_pkg::out_rsp_t resolve_binding(input ipmac_pkg::in_req_t r);
    ipmac_pkg::out_rsp_t        rsp;
    logic [ipmac_pkg::IP_W-1:0] host_ip;
    int                         slot;
    int                         i;
    rsp  = '0;
    slot = -1;
    if (r.func == ipmac_pkg::FUNC_ADD) begin
      host_ip = to_host(r.ip_addr);
      for (i = 0; i < bound_count && slot < 0; i++)
        if (bound_mac[i] == r.mac_addr) slot = i;
      if (slot >= 0) begin
        bound_ip[slot] = host_ip;
        rsp.status     = ipmac_pkg::ST_UPDATED;
      end else if (bound_count < TABLE_ENTRIES) begin
        bound_ip[bound_count]  = host_ip;
        bound_mac[bound_count] = r.mac_addr;
        bound_count++;
        rsp.status = ipmac_pkg::ST_INSERTED;
      end else begin
        rsp.status = ipmac_pkg::ST_FULL;
      end
    end else begin
      rsp.status = ipmac_pkg::ST_MISS;
      for (i = 0; i < bound_count && slot < 0; i++)
        if (bound_ip[i] == r.ip_addr) slot = i;
      if (slot >= 0) begin
        rsp.status  = ipmac_pkg::ST_HIT;
        rsp.mac_out = bound_mac[slot];
      end
    end
    return rsp;
  endfunction

  task automatic flag_mismatch(input string what, input logic [ipmac_pkg::MAC_W-1:0] got,
                               input logic [ipmac_pkg::MAC_W-1:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    n_mismatch++;
  endtask

  task automatic issue_req(input ipmac_pkg::in_req_t r, input logic typed,
                           input ipmac_pkg::out_rsp_t typed_rsp);
    ipmac_pkg::out_rsp_t rsp;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rsp = resolve_binding(r);
    awaited_rsp.push_back(typed ? typed_rsp : rsp);
    if (r.func == ipmac_pkg::FUNC_ADD) begin
      added_macs.push_back(r.mac_addr);
      added_ips.push_back(r.ip_addr);
    end
    n_issued++;
    calm = (n_issued >= CALM_FIRST && n_issued < CALM_LAST);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_rsp.size() == 0) begin
        flag_mismatch("result with no request pending", out_rsp.mac_out, '0);
      end else begin
        head_rsp = awaited_rsp.pop_front();
        if (out_rsp.status !== head_rsp.status)
          flag_mismatch("status", out_rsp.status, head_rsp.status);
        if (out_rsp.mac_out !== head_rsp.mac_out)
          flag_mismatch("mac_out", out_rsp.mac_out, head_rsp.mac_out);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ipmac_pkg::in_req_t  r;
    ipmac_pkg::out_rsp_t t;
    logic [63:0]         wide;
    int                  k;
    int                  pick;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req      = '0;
    out_stall   = 1'b0;
    bound_count = 0;
    n_issued    = 0;
    n_mismatch  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_PROBES; k++) begin
      r.func     = probes[k].func;
      r.ip_addr  = probes[k].ip;
      r.mac_addr = probes[k].mac;
      t.status   = probes[k].status;
      t.mac_out  = probes[k].mac_out;
      issue_req(r, probes[k].typed, t);
    end

    // Fresh adds fill the table partway through, so later adds also meet a full table.
    for (k = 0; k < N_RANDOM; k++) begin
      pick       = $urandom_range(99);
      wide       = {$urandom(), $urandom()};
      r.func     = ipmac_pkg::FUNC_ADD;
      r.mac_addr = wide[ipmac_pkg::MAC_W-1:0];
      r.ip_addr  = $urandom();
      if (pick < 40) begin
        if (added_ips.size() > 0 && $urandom_range(3) == 0)
          r.ip_addr = added_ips[$urandom_range(added_ips.size() - 1)];
      end else if (pick < 60) begin
        if (added_macs.size() > 0)
          r.mac_addr = added_macs[$urandom_range(added_macs.size() - 1)];
      end else begin
        r.func = ipmac_pkg::FUNC_LOOKUP;
        if (pick < 90 && added_ips.size() > 0)
          r.ip_addr = to_host(added_ips[$urandom_range(added_ips.size() - 1)]);
      end
      issue_req(r, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
